// ----- hdl/sspc_pkg.sv -----
// Shared types and codes for the servo status packet checker.
package sspc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_ID   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_ANY_ID = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PARAM_LEN     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_LIMIT  = 3'd5;

  // Input opcodes.
  localparam logic [1:0] OP_ARM     = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result codes.
  localparam logic [2:0] RC_OK     = 3'd0;
  localparam logic [2:0] RC_SHORT  = 3'd1;
  localparam logic [2:0] RC_HEADER = 3'd2;
  localparam logic [2:0] RC_ID     = 3'd3;
  localparam logic [2:0] RC_LEN    = 3'd4;
  localparam logic [2:0] RC_CSUM   = 3'd5;

  // Result kinds.
  localparam logic KIND_PARAM   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Length byte carries the parameter count plus the id-free overhead.
  localparam logic [8:0] LEN_OVERHEAD = 9'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } sspc_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [2:0] result_code;
    logic [7:0] reply_id;
    logic [7:0] reply_status;
    logic       last;
  } sspc_result_t;

endpackage

// ----- hdl/servo_status_packet_checker_core.sv -----
// Servo status packet checker: one transaction per cycle while item_stall is low,
// registered results. Each accepted transaction (arm, received byte or timeout)
// updates the packet parser in the same cycle, and any result it causes (a
// parameter byte or the final verdict) is registered into the result register, or
// into the skid register if the result register holds one that is not taken. A new
// transaction can be accepted every cycle while item_stall is low. Results sit in a
// two-entry output buffer (result register plus skid register), so the input keeps
// flowing while one result waits; item_stall rises only when both entries are full,
// and falls in the cycle after the result side takes one. Configuration writes take
// effect at once and should be made only while no packet is in flight.
module servo_status_packet_checker_core
  import sspc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  sspc_item_t             item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output sspc_result_t           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_STATUS,
    PH_PARAM,
    PH_CSUM
  } phase_t;

  // Configuration registers.
  logic [7:0] header_byte_first;
  logic [7:0] header_byte_second;
  logic [7:0] expected_id;
  logic       accept_any_id;
  logic [7:0] expected_param_len;
  logic [7:0] header_search_limit;

  // Parser state.
  phase_t     phase, phase_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic [7:0] search_count, search_count_next;
  logic [7:0] got_id, got_id_next;
  logic [7:0] got_status, got_status_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] params_seen, params_seen_next;
  logic       len_ok, len_ok_next;

  // Output buffer.
  logic         skid_valid;
  sspc_result_t skid;

  logic         accept;
  logic         pop;
  logic         res_fire;
  sspc_result_t res;
  logic [7:0]   search_count_inc;
  logic [7:0]   params_seen_inc;
  logic [7:0]   b;

  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign item_stall = skid_valid;
  assign b          = item.rx_byte;

  assign search_count_inc = search_count + 8'd1;
  assign params_seen_inc  = params_seen + 8'd1;

  always_comb begin
    phase_next         = phase;
    previous_byte_next = previous_byte;
    search_count_next  = search_count;
    got_id_next        = got_id;
    got_status_next    = got_status;
    running_sum_next   = running_sum;
    params_seen_next   = params_seen;
    len_ok_next        = len_ok;
    res_fire           = 1'b0;
    res.kind           = KIND_VERDICT;
    res.param_byte     = 8'd0;
    res.param_index    = 8'd0;
    res.result_code    = RC_OK;
    res.reply_id       = got_id;
    res.reply_status   = 8'd0;
    res.last           = 1'b1;

    if (item.opcode == OP_ARM) begin
      phase_next         = PH_HUNT;
      previous_byte_next = 8'd0;
      search_count_next  = 8'd0;
      got_id_next        = 8'd0;
      got_status_next    = 8'd0;
      running_sum_next   = 8'd0;
      params_seen_next   = 8'd0;
      len_ok_next        = 1'b0;
    end else if (phase != PH_IDLE && item.opcode == OP_TIMEOUT) begin
      res_fire   = 1'b1;
      phase_next = PH_IDLE;
      case (phase)
        PH_PARAM: res.result_code = RC_SHORT;
        PH_CSUM:  res.result_code = RC_CSUM;
        default:  res.result_code = RC_HEADER;
      endcase
    end else if (phase != PH_IDLE && item.opcode == OP_BYTE) begin
      case (phase)
        PH_HUNT: begin
          search_count_next = search_count_inc;
          if (search_count != 8'd0 && previous_byte == header_byte_first &&
              b == header_byte_second) begin
            phase_next = PH_ID;
          end else begin
            previous_byte_next = b;
            // A limit of zero gives up on the first byte, like a limit of one.
            if (search_count_inc >= header_search_limit) begin
              res_fire        = 1'b1;
              res.result_code = RC_HEADER;
              phase_next      = PH_IDLE;
            end
          end
        end
        PH_ID: begin
          got_id_next      = b;
          running_sum_next = b;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          len_ok_next      = ({1'b0, b} == ({1'b0, expected_param_len} + LEN_OVERHEAD));
          running_sum_next = running_sum + b;
          phase_next       = PH_STATUS;
        end
        PH_STATUS: begin
          got_status_next  = b;
          running_sum_next = running_sum + b;
          // A wrong id takes precedence over a wrong length.
          if (!accept_any_id && got_id != expected_id) begin
            res_fire        = 1'b1;
            res.result_code = RC_ID;
            phase_next      = PH_IDLE;
          end else if (!len_ok) begin
            res_fire        = 1'b1;
            res.result_code = RC_LEN;
            phase_next      = PH_IDLE;
          end else begin
            phase_next = (expected_param_len == 8'd0) ? PH_CSUM : PH_PARAM;
          end
        end
        PH_PARAM: begin
          res_fire         = 1'b1;
          res.kind         = KIND_PARAM;
          res.param_byte   = b;
          res.param_index  = params_seen;
          res.last         = 1'b0;
          running_sum_next = running_sum + b;
          params_seen_next = params_seen_inc;
          if (params_seen_inc >= expected_param_len) begin
            phase_next = PH_CSUM;
          end
        end
        PH_CSUM: begin
          res_fire   = 1'b1;
          phase_next = PH_IDLE;
          if (b == ~running_sum) begin
            res.result_code  = RC_OK;
            res.reply_status = got_status;
          end else begin
            res.result_code = RC_CSUM;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte_first   <= 8'd255;
      header_byte_second  <= 8'd255;
      expected_id         <= 8'd1;
      accept_any_id       <= 1'b0;
      expected_param_len  <= 8'd0;
      header_search_limit <= 8'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_byte_first   <= cfg_data;
        REG_HEADER_SECOND: header_byte_second  <= cfg_data;
        REG_EXPECTED_ID:   expected_id         <= cfg_data;
        REG_ACCEPT_ANY_ID: accept_any_id       <= cfg_data[0];
        REG_PARAM_LEN:     expected_param_len  <= cfg_data;
        REG_SEARCH_LIMIT:  header_search_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      previous_byte <= 8'd0;
      search_count  <= 8'd0;
      got_id        <= 8'd0;
      got_status    <= 8'd0;
      running_sum   <= 8'd0;
      params_seen   <= 8'd0;
      len_ok        <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      previous_byte <= previous_byte_next;
      search_count  <= search_count_next;
      got_id        <= got_id_next;
      got_status    <= got_status_next;
      running_sum   <= running_sum_next;
      params_seen   <= params_seen_next;
      len_ok        <= len_ok_next;
    end
  end

  // The skid entry fills only when a new result arrives while the result
  // register holds one that is not taken in this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (accept && res_fire) begin
      if (!result_valid || pop) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid;
      end
    end else if (accept && res_fire) begin
      if (!result_valid || pop) begin
        result <= res;
      end else begin
        skid <= res;
      end
    end
  end

  a_skid_behind_result : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds a result while the result register is empty");

  a_idle_ignores : assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_IDLE && item.opcode != OP_ARM) |=> phase == PH_IDLE)
    else $error("parser left idle without an arm");

  a_verdict_is_last : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind == result.last))
    else $error("last flag disagrees with result kind");

  a_param_fields : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_PARAM) |->
      (result.result_code == RC_OK && result.reply_status == 8'd0))
    else $error("parameter result carries verdict fields");

  a_status_only_ok : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_code != RC_OK) |-> result.reply_status == 8'd0)
    else $error("status byte reported on a failed packet");

endmodule
